// File: hw/rtl/adaptive_send_probability_aimd_unit_macros.svh
// Assertion macros for the adaptive send-probability unit.
`ifndef ADAPTIVE_SEND_PROBABILITY_AIMD_UNIT_MACROS_SVH
`define ADAPTIVE_SEND_PROBABILITY_AIMD_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
`define ASP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASP_ASSERT_SAME(label, clk, rst, ante, cons)
`define ASP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/asp_aimd_pkg.sv
// Package: modes, limits and additive-increase step table for the AIMD unit.
package asp_aimd_pkg;

  typedef enum logic [1:0] {
    MODE_ORIG_SEND = 2'd0,
    MODE_FWD_SEND  = 2'd1,
    MODE_ORIG_ACK  = 2'd2,
    MODE_FWD_ACK   = 2'd3
  } mode_t;

  localparam int unsigned PROB_W    = 16;
  localparam int unsigned CHILD_W   = 4;
  localparam logic [PROB_W-1:0]  PROB_MAX  = 16'hFFFF;
  localparam logic [CHILD_W-1:0] CHILD_MAX = 4'd9;

  // Additive-increase step by child count; entry 0 also serves forwarded sends.
  function automatic logic [PROB_W-1:0] step_lookup(input logic [CHILD_W-1:0] idx);
    logic [PROB_W-1:0] step;
    case (idx)
      4'd0:    step = 16'd6553;
      4'd1:    step = 16'd3276;
      4'd2:    step = 16'd2184;
      4'd3:    step = 16'd1638;
      4'd4:    step = 16'd1320;
      4'd5:    step = 16'd1092;
      4'd6:    step = 16'd936;
      4'd7:    step = 16'd819;
      4'd8:    step = 16'd655;
      default: step = 16'd595;
    endcase
    return step;
  endfunction

endpackage

// File: hw/rtl/adaptive_send_probability_aimd_unit.sv
// Path: the input register feeds the result register; an input waits there while out_ready
// stalls. Throughput: one item per cycle unless stalled; the probability update is a
// combinational compare, shift, add and saturate, so back-to-back items see the updated state.
// Reset (rst, synchronous): both probabilities 65535, ack-pending flags clear,
// child_count 0, pipeline empty.
`include "adaptive_send_probability_aimd_unit_macros.svh"

module adaptive_send_probability_aimd_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [asp_aimd_pkg::CHILD_W-1:0]      child_count,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            mode,
  input  logic [asp_aimd_pkg::PROB_W-1:0]       random_value,
  input  logic                                  lower_busy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  granted,
  output logic                                  phase_change,
  output logic [asp_aimd_pkg::PROB_W-1:0]       probability_now
);

  // Configuration
  logic [asp_aimd_pkg::CHILD_W-1:0] child_cnt;

  // Input stage
  logic                              s_valid;
  asp_aimd_pkg::mode_t               s_mode;
  logic [asp_aimd_pkg::PROB_W-1:0]   s_rnd;
  logic                              s_busy;

  // State
  logic [asp_aimd_pkg::PROB_W-1:0]   origin_prob, origin_prob_next;
  logic [asp_aimd_pkg::PROB_W-1:0]   forward_prob, forward_prob_next;
  logic                              origin_pending, origin_pending_next;
  logic                              forward_pending, forward_pending_next;

  // Datapath
  logic                              issue;
  logic                              is_fwd;
  logic                              is_send;
  logic                              hit;
  logic                              cut;
  logic                              refused;
  logic [asp_aimd_pkg::PROB_W-1:0]   prob_sel;
  logic [asp_aimd_pkg::PROB_W-1:0]   prob_base;
  logic [asp_aimd_pkg::PROB_W-1:0]   step;
  logic [asp_aimd_pkg::PROB_W:0]     sum;
  logic [asp_aimd_pkg::PROB_W-1:0]   prob_inc;
  logic                              granted_next;
  logic                              phase_next;
  logic [asp_aimd_pkg::PROB_W-1:0]   prob_now_next;

  assign issue    = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      child_cnt <= '0;
    end else if (cfg_wr_en) begin
      child_cnt <= (child_count > asp_aimd_pkg::CHILD_MAX) ? asp_aimd_pkg::CHILD_MAX
                                                           : child_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_mode <= asp_aimd_pkg::mode_t'(mode);
      s_rnd  <= random_value;
      s_busy <= lower_busy;
    end
  end

  always_comb begin
    is_fwd   = (s_mode == asp_aimd_pkg::MODE_FWD_SEND) ||
               (s_mode == asp_aimd_pkg::MODE_FWD_ACK);
    is_send  = (s_mode == asp_aimd_pkg::MODE_ORIG_SEND) ||
               (s_mode == asp_aimd_pkg::MODE_FWD_SEND);
    prob_sel = is_fwd ? forward_prob : origin_prob;
    hit      = prob_sel >= s_rnd;
    refused  = hit && s_busy;
    cut      = hit && (is_fwd ? forward_pending : origin_pending);

    // Multiplicative decrease: half for originated, three quarters for forwarded
    if (!cut) begin
      prob_base = prob_sel;
    end else if (is_fwd) begin
      prob_base = prob_sel - (prob_sel >> 2);
    end else begin
      prob_base = prob_sel >> 1;
    end

    step     = is_fwd ? asp_aimd_pkg::step_lookup('0) : asp_aimd_pkg::step_lookup(child_cnt);
    sum      = {1'b0, prob_base} + {1'b0, step};
    prob_inc = (sum >= {1'b0, asp_aimd_pkg::PROB_MAX}) ? asp_aimd_pkg::PROB_MAX
                                                       : sum[asp_aimd_pkg::PROB_W-1:0];

    origin_prob_next     = origin_prob;
    forward_prob_next    = forward_prob;
    origin_pending_next  = origin_pending;
    forward_pending_next = forward_pending;
    granted_next         = 1'b0;
    phase_next           = 1'b0;
    prob_now_next        = prob_sel;

    case (s_mode)
      asp_aimd_pkg::MODE_ORIG_SEND: begin
        if (refused) begin
          phase_next = 1'b1;
        end else begin
          granted_next     = hit;
          phase_next       = cut;
          origin_prob_next = prob_inc;
          prob_now_next    = prob_inc;
          if (hit) begin
            origin_pending_next = 1'b1;
          end
        end
      end
      asp_aimd_pkg::MODE_FWD_SEND: begin
        if (!refused) begin
          granted_next      = hit;
          forward_prob_next = prob_inc;
          prob_now_next     = prob_inc;
          if (hit) begin
            forward_pending_next = 1'b1;
          end
        end
      end
      asp_aimd_pkg::MODE_ORIG_ACK: begin
        origin_pending_next = 1'b0;
      end
      default: begin
        forward_pending_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_prob     <= asp_aimd_pkg::PROB_MAX;
      forward_prob    <= asp_aimd_pkg::PROB_MAX;
      origin_pending  <= 1'b0;
      forward_pending <= 1'b0;
    end else if (issue) begin
      origin_prob     <= origin_prob_next;
      forward_prob    <= forward_prob_next;
      origin_pending  <= origin_pending_next;
      forward_pending <= forward_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      granted         <= granted_next;
      phase_change    <= phase_next;
      probability_now <= prob_now_next;
    end
  end

  `ASP_ASSERT_SAME(a_child_sat, clk, rst, 1'b1, child_cnt <= asp_aimd_pkg::CHILD_MAX)
  `ASP_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASP_ASSERT_NEXT(a_fwd_keeps_origin, clk, rst, issue && is_fwd, $stable(origin_prob))
  `ASP_ASSERT_NEXT(a_orig_ack_clears, clk, rst,
                   issue && (s_mode == asp_aimd_pkg::MODE_ORIG_ACK), !origin_pending)
  `ASP_ASSERT_NEXT(a_grant_sets_pending, clk, rst,
                   issue && is_send && hit && !s_busy,
                   granted && (origin_pending || forward_pending))

endmodule
